@@ src/tick_driven_clock_display_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clock display scanner
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_CLOCK_DISPLAY_SCANNER_ASSERT_SVH
`define TICK_DRIVEN_CLOCK_DISPLAY_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is asserted
`define TDCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tdcs assertion failed");

// checked property, also active during reset
`define TDCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tdcs assertion failed");

`else

`define TDCS_ASSERT(lbl, clk, rst_n, prop)
`define TDCS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/tdcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tdcs_pkg
// Shared types, reset values and the seven-segment table of the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdcs_pkg;

  localparam int MatrixColumns = 8;
  localparam int DigitCount    = 4;
  localparam int ColW          = $clog2(MatrixColumns);
  localparam int SlotW         = $clog2(DigitCount);

  // register reset values
  localparam logic [63:0] IMAGE_RESET  = 64'd7378724120842091544;
  localparam logic [7:0]  SCAN_RESET   = 8'd5;
  localparam logic [7:0]  DIGIT_RESET  = 8'd25;
  localparam logic [15:0] SECOND_RESET = 16'd100;

  // clock state reset values and wrap limits
  localparam logic [4:0] HOUR_RESET   = 5'd15;
  localparam logic [5:0] MINUTE_RESET = 6'd8;
  localparam logic [5:0] SECOND_INIT  = 6'd50;
  localparam logic [5:0] MINUTE_WRAP  = 6'd60;
  localparam logic [5:0] SECOND_WRAP  = 6'd60;
  localparam logic [4:0] HOUR_WRAP    = 5'd24;

  // register map (index = byte address / 8)
  typedef enum logic [1:0] {
    REG_IMAGE  = 2'd0,
    REG_SCAN   = 2'd1,
    REG_DIGIT  = 2'd2,
    REG_SECOND = 2'd3
  } tdcs_reg_e;

  // active-low a..g patterns; codes above 9 show 0
  localparam logic [6:0] SEG_TABLE [16] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
    7'h00, 7'h18, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40
  };

  typedef struct packed {
    logic [63:0] image;
    logic [7:0]  scan_period;
    logic [7:0]  digit_period;
    logic [15:0] second_period;
  } tdcs_cfg_t;

  typedef struct packed {
    logic [7:0] column_enable_n;
    logic [7:0] row_drive_n;
    logic [3:0] digit_enable_n;
    logic [6:0] segments_n;
    logic       colon_dot;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
  } tdcs_result_t;

endpackage

`default_nettype wire

@@ src/tdcs_core.sv @@
// ----------------------------------------------------------------------------
// tdcs_core
// Tick dividers, scan counters, HH:MM:SS clock and display decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdcs_core
  import tdcs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,     // a transaction is taken this cycle
  input  wire logic         advance_i,
  input  wire tdcs_cfg_t    cfg_i,
  output tdcs_result_t      res_o       // display after this transaction
);

  logic [7:0]      scan_left_q, scan_left_d;
  logic [7:0]      digit_left_q, digit_left_d;
  logic [15:0]     sec_left_q, sec_left_d;
  logic [ColW-1:0] col_q, col_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [4:0]      hour_q, hour_d;
  logic [5:0]      min_q, min_d;
  logic [5:0]      sec_q, sec_d;
  logic            dot_q, dot_d;

  logic            tick;
  logic [5:0]      sec_inc, min_inc;
  logic [4:0]      hour_inc;

  // split a small value into decimal tens and units
  function automatic logic [7:0] dec_split(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] units;
    begin
      if (v >= 6'd60)      tens = 4'd6;
      else if (v >= 6'd50) tens = 4'd5;
      else if (v >= 6'd40) tens = 4'd4;
      else if (v >= 6'd30) tens = 4'd3;
      else if (v >= 6'd20) tens = 4'd2;
      else if (v >= 6'd10) tens = 4'd1;
      else                 tens = 4'd0;
      units = v - 6'(tens) * 6'd10;
      dec_split = {tens, units[3:0]};
    end
  endfunction

  assign tick = step_i && advance_i;

  // next-state logic for dividers and the clock
  always_comb begin
    scan_left_d  = scan_left_q;
    digit_left_d = digit_left_q;
    sec_left_d   = sec_left_q;
    col_d        = col_q;
    slot_d       = slot_q;
    hour_d       = hour_q;
    min_d        = min_q;
    sec_d        = sec_q;
    dot_d        = dot_q;
    sec_inc      = sec_q + 6'd1;
    min_inc      = min_q;
    hour_inc     = hour_q;

    // clock increment with carries
    if (sec_inc >= SECOND_WRAP) begin
      sec_inc = 6'd0;
      min_inc = min_q + 6'd1;
    end
    if (min_inc >= MINUTE_WRAP) begin
      min_inc  = 6'd0;
      hour_inc = hour_q + 5'd1;
    end
    if (hour_inc >= HOUR_WRAP) begin
      hour_inc = 5'd0;
    end

    if (tick) begin
      if (scan_left_q <= 8'd1) begin
        scan_left_d = cfg_i.scan_period;
        col_d       = col_q + 1'b1;
      end else begin
        scan_left_d = scan_left_q - 8'd1;
      end

      if (digit_left_q <= 8'd1) begin
        digit_left_d = cfg_i.digit_period;
        slot_d       = slot_q + 1'b1;
      end else begin
        digit_left_d = digit_left_q - 8'd1;
      end

      if (sec_left_q <= 16'd1) begin
        sec_left_d = cfg_i.second_period;
        dot_d      = ~dot_q;
        sec_d      = sec_inc;
        min_d      = min_inc;
        hour_d     = hour_inc;
      end else begin
        sec_left_d = sec_left_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_left_q  <= SCAN_RESET;
      digit_left_q <= DIGIT_RESET;
      sec_left_q   <= SECOND_RESET;
      col_q        <= '0;
      slot_q       <= '0;
      hour_q       <= HOUR_RESET;
      min_q        <= MINUTE_RESET;
      sec_q        <= SECOND_INIT;
      dot_q        <= 1'b0;
    end else begin
      scan_left_q  <= scan_left_d;
      digit_left_q <= digit_left_d;
      sec_left_q   <= sec_left_d;
      col_q        <= col_d;
      slot_q       <= slot_d;
      hour_q       <= hour_d;
      min_q        <= min_d;
      sec_q        <= sec_d;
      dot_q        <= dot_d;
    end
  end

  // display decode from the updated state
  logic [7:0][7:0] img_rows;
  logic [7:0]      hour_bcd, min_bcd;
  logic [3:0]      digit_val;
  logic [7:0]      rows_n;

  assign img_rows = cfg_i.image;
  assign hour_bcd = dec_split({1'b0, hour_d});
  assign min_bcd  = dec_split(min_d);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rows_n[i] = ~img_rows[i][col_d];
    end
  end

  always_comb begin
    case (slot_d)
      2'd0:    digit_val = hour_bcd[7:4];
      2'd1:    digit_val = hour_bcd[3:0];
      2'd2:    digit_val = min_bcd[7:4];
      default: digit_val = min_bcd[3:0];
    endcase
  end

  always_comb begin
    res_o.column_enable_n = ~(8'd1 << col_d);
    res_o.row_drive_n     = rows_n;
    res_o.digit_enable_n  = ~(4'd1 << slot_d);
    res_o.segments_n      = SEG_TABLE[digit_val];
    res_o.colon_dot       = dot_d;
    res_o.hours_now       = hour_d;
    res_o.minutes_now     = min_d;
    res_o.seconds_now     = sec_d;
  end

endmodule

`default_nettype wire

@@ src/tick_driven_clock_display_scanner.sv @@
// ----------------------------------------------------------------------------
// tick_driven_clock_display_scanner
// LED matrix and four-digit clock display scanner driven by base ticks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one transaction per cycle while s_axis_tready is high;
//    tdata bit 0 = advance. A 1 applies one base tick to the three
//    dividers, a 0 only re-presents the current display.
//  - Output stream: exactly one result per input transaction, in order.
//  - Each result is registered in the result register or the skid entry.
//  - Throughput: one transaction per cycle unless s_axis_tready is low;
//    the state update and decode sit in one combinational step between
//    the input handshake and the result register.
//  - Stall: a two-entry output buffer (result register plus skid entry)
//    keeps s_axis_tready high while one result waits; it drops only when
//    both entries are full.
//  - Reset: registers take their default values (5/25/100 tick periods,
//    clock 15:08:50, column and digit 0); both buffer entries empty.
//  - APB: 64-bit registers at 8*index; write only while the stream is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tick_driven_clock_display_scanner_assert.svh"

module tick_driven_clock_display_scanner
  import tdcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] advance, [7:1] zero
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] column_enable_n,
                                           // [15:8] row_drive_n,
                                           // [19:16] digit_enable_n,
                                           // [26:20] segments_n,
                                           // [27] colon_dot,
                                           // [32:28] hours_now,
                                           // [38:33] minutes_now,
                                           // [44:39] seconds_now, [47:45] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  tdcs_cfg_t    cfg_q;
  tdcs_result_t res_new;
  tdcs_result_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         in_fire, out_fire, cfg_wr;
  tdcs_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = tdcs_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image         <= IMAGE_RESET;
      cfg_q.scan_period   <= SCAN_RESET;
      cfg_q.digit_period  <= DIGIT_RESET;
      cfg_q.second_period <= SECOND_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IMAGE:  cfg_q.image         <= pwdata;
        REG_SCAN:   cfg_q.scan_period   <= pwdata[7:0];
        REG_DIGIT:  cfg_q.digit_period  <= pwdata[7:0];
        REG_SECOND: cfg_q.second_period <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_IMAGE:  prdata = cfg_q.image;
      REG_SCAN:   prdata = {56'd0, cfg_q.scan_period};
      REG_DIGIT:  prdata = {56'd0, cfg_q.digit_period};
      REG_SECOND: prdata = {48'd0, cfg_q.second_period};
      default:    prdata = '0;
    endcase
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  tdcs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .advance_i (s_axis_tdata[0]),
    .cfg_i     (cfg_q),
    .res_o     (res_new)
  );

  // result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.seconds_now, out_q.minutes_now, out_q.hours_now,
                          out_q.colon_dot, out_q.segments_n, out_q.digit_enable_n,
                          out_q.row_drive_n, out_q.column_enable_n};

  // checks
  `TDCS_ASSERT_ALWAYS(a_skid_needs_out, clk_i, skid_valid_q |-> out_valid_q)
  `TDCS_ASSERT(a_take_fills_out, clk_i, rst_ni, in_fire && !out_valid_q |=> out_valid_q)
  `TDCS_ASSERT(a_onehot_scan, clk_i, rst_ni, m_axis_tvalid |-> ($onehot(~m_axis_tdata[7:0]) && $onehot(~m_axis_tdata[19:16])))
  `TDCS_ASSERT(a_time_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[32:28] < 5'd24 && m_axis_tdata[38:33] < 6'd60 && m_axis_tdata[44:39] < 6'd60))

endmodule

`default_nettype wire

@@ tb/sv/tick_driven_clock_display_scanner_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_driven_clock_display_scanner_test
// Self-checking bench for the clock display scanner. A short table of
// directed transactions runs first, then randomized phases with fresh
// register settings and one fast back-to-back burst at one clock second per
// tick. Every display result is compared field by field against a local
// model of the dividers, the matrix scan, the digit scan and the HH:MM:SS
// clock. Both stream sides idle at random, and the output side holds off
// once for a long stretch.
// ----------------------------------------------------------------------------

module tick_driven_clock_display_scanner_test;
  import tdcs_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 103;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned SWEEP_PHASE  = 5;
  localparam int unsigned SWEEP_TICKS  = 120;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    tdcs_reg_e    reg_sel;
    logic [63:0]  value;
    logic         advance;
    logic         fixed;
    tdcs_result_t golden;
  } dir_row_t;

  typedef struct {
    logic         fixed;
    tdcs_result_t view;
  } tick_tag_t;

  // display right after reset: column 0 of the letter image is empty,
  // hour tens digit 1 selected, clock at 15:08:50
  localparam tdcs_result_t RESET_VIEW = '{
    column_enable_n: 8'hFE, row_drive_n: 8'hFF, digit_enable_n: 4'hE,
    segments_n: 7'h79, colon_dot: 1'b0, hours_now: 5'd15,
    minutes_now: 6'd8, seconds_now: 6'd50
  };

  localparam int DIR_LEN = 28;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // reset state shown without a tick
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b0, 1'b1, RESET_VIEW},
    // five ticks: the matrix column steps on the fifth
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    // full picture, zero scan period hidden under junk high bits,
    // slowest digit and second dividers
    '{ROW_WRITE, REG_IMAGE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SCAN,   64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIGIT,  64'h0000_0000_0000_00FF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SECOND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b0, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    // blank picture, slowest scan, zero digit and second periods
    '{ROW_WRITE, REG_IMAGE,  64'd0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SCAN,   64'h0000_0000_0000_00FF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIGIT,  64'd0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SECOND, 64'h0000_0000_ABCD_0000, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b0, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b0, 1'b0, '0},
    '{ROW_ITEM,  REG_IMAGE,  64'd0,                 1'b1, 1'b0, '0}
  };

  // DUT ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  // model copy of registers and state
  logic [63:0] pic;
  logic [7:0]  scan_per, digit_per;
  logic [15:0] sec_per;
  logic [7:0]  scan_left, digit_left;
  logic [15:0] sec_left;
  logic [2:0]  col;
  logic [1:0]  slot;
  logic [4:0]  hh;
  logic [5:0]  mm, ss;
  logic        dot;

  tdcs_result_t pending_views [$];
  tick_tag_t    tick_tags [$];
  int unsigned  fail_count    = 0;
  int unsigned  views_checked = 0;
  bit           fast_mode     = 1'b0;

  tick_driven_clock_display_scanner u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // apply one tick (or none) to the model and return the display it shows
  function automatic tdcs_result_t tick_view(logic adv);
    tdcs_result_t v;
    int unsigned  digit;
    int           i;
    if (adv) begin
      if (scan_left <= 8'd1) begin
        scan_left = scan_per;
        col       = col + 3'd1;
      end else begin
        scan_left = scan_left - 8'd1;
      end
      if (digit_left <= 8'd1) begin
        digit_left = digit_per;
        slot       = slot + 2'd1;
      end else begin
        digit_left = digit_left - 8'd1;
      end
      if (sec_left <= 16'd1) begin
        sec_left = sec_per;
        dot      = ~dot;
        ss       = ss + 6'd1;
        if (ss >= 6'd60) begin
          ss = '0;
          mm = mm + 6'd1;
        end
        if (mm >= 6'd60) begin
          mm = '0;
          hh = hh + 5'd1;
        end
        if (hh >= 5'd24) hh = '0;
      end else begin
        sec_left = sec_left - 16'd1;
      end
    end

    v.column_enable_n = ~(8'd1 << col);
    for (i = 0; i < 8; i++) v.row_drive_n[i] = ~pic[8 * i + int'(col)];
    v.digit_enable_n = ~(4'd1 << slot);
    case (slot)
      2'd0:    digit = int'(hh) / 10;
      2'd1:    digit = int'(hh) % 10;
      2'd2:    digit = int'(mm) / 10;
      default: digit = int'(mm) % 10;
    endcase
    // active-low a..g, anything outside 1..9 shows 0
    case (digit)
      1:       v.segments_n = 7'h79;
      2:       v.segments_n = 7'h24;
      3:       v.segments_n = 7'h30;
      4:       v.segments_n = 7'h19;
      5:       v.segments_n = 7'h12;
      6:       v.segments_n = 7'h02;
      7:       v.segments_n = 7'h78;
      8:       v.segments_n = 7'h00;
      9:       v.segments_n = 7'h18;
      default: v.segments_n = 7'h40;
    endcase
    v.colon_dot   = dot;
    v.hours_now   = hh;
    v.minutes_now = mm;
    v.seconds_now = ss;
    return v;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // period value: extremes, zero, or small; junk above the width at times
  function automatic logic [63:0] pick_period(logic [63:0] top);
    logic [63:0] v;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0)      v = 64'd0;
    else if (r == 1) v = 64'd1;
    else if (r == 2) v = top;
    else             v = 64'($urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0) v = v | ({$urandom, $urandom} & ~top);
    return v;
  endfunction

  function automatic logic [63:0] pick_image();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // APB write, then read the register back
  task automatic write_register(tdcs_reg_e sel, logic [63:0] value);
    logic [63:0] stored;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_IMAGE: begin
        pic    = value;
        stored = value;
      end
      REG_SCAN: begin
        scan_per = value[7:0];
        stored   = {56'd0, value[7:0]};
      end
      REG_DIGIT: begin
        digit_per = value[7:0];
        stored    = {56'd0, value[7:0]};
      end
      REG_SECOND: begin
        sec_per = value[15:0];
        stored  = {48'd0, value[15:0]};
      end
      default: begin
        stored = '0;
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      $display("%0t: register %s read expected %0h, got %0h", $time, sel.name(), stored,
               prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one tick transaction and wait until it is taken
  task automatic offer_tick(logic adv, logic fixed, tdcs_result_t golden);
    int unsigned gap;
    tick_tag_t   tag;
    gap = fast_mode ? 0 : idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tag.fixed = fixed;
    tag.view  = golden;
    tick_tags.push_back(tag);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, adv};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait for every outstanding display
  task automatic drain_views();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned count);
    drain_views();
    write_register(REG_IMAGE, pick_image());
    write_register(REG_SCAN, pick_period(64'hFF));
    write_register(REG_DIGIT, pick_period(64'hFF));
    write_register(REG_SECOND, pick_period(64'hFFFF));
    repeat (count) offer_tick($urandom_range(0, 4) != 0, 1'b0, '0);
  endtask

  // result checker and expectation capture; compare before push so a result
  // shown in the cycle its own transaction is taken can not match it
  always @(posedge clk_i) begin
    tdcs_result_t got;
    tdcs_result_t want;
    tick_tag_t    tag;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        views_checked++;
        got.column_enable_n = m_axis_tdata[7:0];
        got.row_drive_n     = m_axis_tdata[15:8];
        got.digit_enable_n  = m_axis_tdata[19:16];
        got.segments_n      = m_axis_tdata[26:20];
        got.colon_dot       = m_axis_tdata[27];
        got.hours_now       = m_axis_tdata[32:28];
        got.minutes_now     = m_axis_tdata[38:33];
        got.seconds_now     = m_axis_tdata[44:39];
        if (pending_views.size() == 0) begin
          $display("%0t: display result with nothing pending, got %0h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_views.pop_front();
          check_field("column_enable_n", want.column_enable_n, got.column_enable_n);
          check_field("row_drive_n", want.row_drive_n, got.row_drive_n);
          check_field("digit_enable_n", want.digit_enable_n, got.digit_enable_n);
          check_field("segments_n", want.segments_n, got.segments_n);
          check_field("colon_dot", want.colon_dot, got.colon_dot);
          check_field("hours_now", want.hours_now, got.hours_now);
          check_field("minutes_now", want.minutes_now, got.minutes_now);
          check_field("seconds_now", want.seconds_now, got.seconds_now);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = tick_view(s_axis_tdata[0]);
        if (tick_tags.size() != 0) begin
          tag = tick_tags.pop_front();
          if (tag.fixed) want = tag.view;
        end
        pending_views.push_back(want);
      end
    end
  end

  // output side: random ready pattern, one long hold-off to back up the input
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (fast_mode) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (!held && views_checked >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
        else repeat ($urandom_range(1, 6)) @(posedge clk_i);
        stall = idle_gap();
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // main sequence
  initial begin
    pic        = IMAGE_RESET;
    scan_per   = SCAN_RESET;
    digit_per  = DIGIT_RESET;
    sec_per    = SECOND_RESET;
    scan_left  = SCAN_RESET;
    digit_left = DIGIT_RESET;
    sec_left   = SECOND_RESET;
    col        = '0;
    slot       = '0;
    hh         = HOUR_RESET;
    mm         = MINUTE_RESET;
    ss         = SECOND_INIT;
    dot        = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_WRITE) begin
        drain_views();
        write_register(DIR_ROWS[i].reg_sel, DIR_ROWS[i].value);
      end else begin
        offer_tick(DIR_ROWS[i].advance, DIR_ROWS[i].fixed, DIR_ROWS[i].golden);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // one clock second per tick, back to back, across minute carries
      if (p == SWEEP_PHASE) begin
        drain_views();
        write_register(REG_SECOND, 64'd1);
        fast_mode = 1'b1;
        repeat (SWEEP_TICKS) offer_tick(1'b1, 1'b0, '0);
        fast_mode = 1'b0;
      end
      run_random_phase(PHASE_ITEMS);
    end

    drain_views();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(40_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/tdcs_pkg.sv
src/tdcs_core.sv
src/tick_driven_clock_display_scanner.sv
tb/sv/tick_driven_clock_display_scanner_test.sv
